FILE: hw/rtl/cfp_pkg.sv
// shared types, constants and crc function for the crc8 framed packet receiver
package cfp_pkg;

    localparam int PAYLOAD_BYTES = 16;
    localparam int STORE_BYTES   = 16;
    localparam int IDX_W         = $clog2(PAYLOAD_BYTES + 1);
    localparam logic [7:0] LEN_MAX  = 8'(PAYLOAD_BYTES + 1);
    localparam logic [7:0] CRC_POLY = 8'h8C;

    localparam logic [7:0] HEADER_FIRST_RST   = 8'h55;
    localparam logic [7:0] HEADER_SECOND_RST  = 8'hAA;
    localparam logic [7:0] TRAILER_FIRST_RST  = 8'h0D;
    localparam logic [7:0] TRAILER_SECOND_RST = 8'h0A;

    localparam logic [7:0] CFG_HEADER_FIRST   = 8'd0;
    localparam logic [7:0] CFG_HEADER_SECOND  = 8'd1;
    localparam logic [7:0] CFG_TRAILER_FIRST  = 8'd2;
    localparam logic [7:0] CFG_TRAILER_SECOND = 8'd3;

    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_CHECK_ERR   = 2'd1;
    localparam logic [1:0] STATUS_TRAILER_ERR = 2'd2;
    localparam logic [1:0] STATUS_BAD_LENGTH  = 2'd3;

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_LENGTH,
        ST_PAYLOAD,
        ST_CHECK,
        ST_TRAIL1,
        ST_TRAIL2
    } state_t;

    typedef struct packed {
        logic [7:0] header_first;
        logic [7:0] header_second;
        logic [7:0] trailer_first;
        logic [7:0] trailer_second;
    } cfg_t;

    typedef struct packed {
        logic               valid;
        logic signed [31:0] word_a;
        logic signed [31:0] word_b;
        logic signed [31:0] word_c;
        logic signed [31:0] word_d;
        logic [1:0]         frame_status;
    } res_t;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: hw/rtl/crc8_framed_packet_receiver.sv
// top level of the crc8 framed packet receiver
// Takes one received byte per transaction on the s_ side and, after the header pair, a length
// byte L, L-1 payload bytes, a check byte and two trailer bytes, gives one transaction on the m_
// side with four little-endian signed words from payload bytes 0-15 and a frame status
// (0 ok, 1 crc mismatch, 2 trailer mismatch, 3 bad length). The check byte is the reflected
// crc-8 (poly 0x8C, init 0) over header, length, payload and one zero byte. One byte can be taken
// every cycle; the byte passes an input register and then the result passes a result register
// before it is valid on the m_ side. While a result waits with m_tready low, the byte in the
// input register is held and s_tready drops. The rate is set by the per-byte crc update, which
// is combinational. Configuration writes are taken at once (cfg_ready high).
module crc8_framed_packet_receiver
    import cfp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // rx_byte[7:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // word_a, word_b, word_c, word_d, frame_status, zero fill
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [7:0]   cfg_data
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg, in_byte_next;
    logic       out_valid_reg, out_valid_next;
    res_t       out_reg, out_next;
    cfg_t       cfg_reg, cfg_next;
    res_t       res;
    logic       advance;

    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {6'd0, out_reg.frame_status, out_reg.word_d, out_reg.word_c,
                        out_reg.word_b, out_reg.word_a};

    cfp_frame_fsm u_fsm (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (in_valid_reg && advance),
        .byte_in    (in_byte_reg),
        .cfg        (cfg_reg),
        .res        (res)
    );

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        in_byte_next   = in_byte_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        cfg_next       = cfg_reg;
        if (s_tready)
        begin
            in_valid_next = s_tvalid;
            in_byte_next  = s_tdata;
        end
        if (advance)
        begin
            out_valid_next = res.valid;
            if (res.valid)
            begin
                out_next = res;
            end
        end
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_HEADER_FIRST:   cfg_next.header_first   = cfg_data;
                CFG_HEADER_SECOND:  cfg_next.header_second  = cfg_data;
                CFG_TRAILER_FIRST:  cfg_next.trailer_first  = cfg_data;
                CFG_TRAILER_SECOND: cfg_next.trailer_second = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg           <= 1'b0;
            out_valid_reg          <= 1'b0;
            cfg_reg.header_first   <= HEADER_FIRST_RST;
            cfg_reg.header_second  <= HEADER_SECOND_RST;
            cfg_reg.trailer_first  <= TRAILER_FIRST_RST;
            cfg_reg.trailer_second <= TRAILER_SECOND_RST;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            cfg_reg       <= cfg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_byte_reg <= in_byte_next;
        out_reg     <= out_next;
    end

`ifndef SYNTHESIS
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("input stage lost a byte under stall");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output backpressure");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |=> m_tvalid)
        else $error("frame result not presented");
`endif

endmodule

FILE: hw/rtl/cfp_frame_fsm.sv
// frame parser: sync search, length, payload store, crc and trailer checks
module cfp_frame_fsm
    import cfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    input  logic [7:0] byte_in,
    input  cfg_t       cfg,
    output res_t       res
);

    state_t           state_reg, state_next;
    logic [7:0]       prev_reg, prev_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       len_reg, len_next;
    logic [7:0]       crc_reg, crc_next;
    logic [7:0]       check_reg, check_next;
    logic             terr_reg, terr_next;
    logic [7:0]       store_reg [STORE_BYTES];
    logic [7:0]       store_next [STORE_BYTES];

    logic start;
    logic byte_len_bad;
    logic len_bad;
    logic payload_done;
    logic trailer_bad;

    assign start        = (prev_reg == cfg.header_first) && (byte_in == cfg.header_second);
    assign byte_len_bad = (byte_in == 8'd0) || (byte_in > LEN_MAX);
    assign len_bad      = (len_reg == 8'd0) || (len_reg > LEN_MAX);
    assign payload_done = (9'(idx_reg) + 9'd2) >= {1'b0, len_reg};
    assign trailer_bad  = terr_reg || (byte_in != cfg.trailer_second);

    // next state
    always_comb
    begin
        state_next = state_reg;
        if (byte_valid)
        begin
            case (state_reg)
                ST_HUNT:
                begin
                    if (start)
                    begin
                        state_next = ST_LENGTH;
                    end
                end
                ST_LENGTH:
                begin
                    if (byte_len_bad || byte_in == 8'd1)
                    begin
                        state_next = ST_CHECK;
                    end
                    else
                    begin
                        state_next = ST_PAYLOAD;
                    end
                end
                ST_PAYLOAD:
                begin
                    if (payload_done)
                    begin
                        state_next = ST_CHECK;
                    end
                end
                ST_CHECK:  state_next = ST_TRAIL1;
                ST_TRAIL1: state_next = ST_TRAIL2;
                ST_TRAIL2: state_next = ST_HUNT;
                default:   state_next = ST_HUNT;
            endcase
        end
    end

    // datapath registers
    always_comb
    begin
        prev_next  = prev_reg;
        idx_next   = idx_reg;
        len_next   = len_reg;
        crc_next   = crc_reg;
        check_next = check_reg;
        terr_next  = terr_reg;
        store_next = store_reg;
        if (byte_valid)
        begin
            case (state_reg)
                ST_HUNT:
                begin
                    if (start)
                    begin
                        idx_next   = '0;
                        len_next   = 8'd0;
                        check_next = 8'd0;
                        terr_next  = 1'b0;
                        crc_next   = crc8_update(crc8_update(8'd0, cfg.header_first),
                                                 cfg.header_second);
                        for (int i = 0; i < STORE_BYTES; i++)
                        begin
                            store_next[i] = 8'd0;
                        end
                    end
                    else
                    begin
                        prev_next = byte_in;
                    end
                end
                ST_LENGTH:
                begin
                    len_next = byte_in;
                    crc_next = crc8_update(crc_reg, byte_in);
                    idx_next = '0;
                end
                ST_PAYLOAD:
                begin
                    if (idx_reg < IDX_W'(STORE_BYTES))
                    begin
                        store_next[idx_reg[3:0]] = byte_in;
                    end
                    crc_next = crc8_update(crc_reg, byte_in);
                    idx_next = idx_reg + 1'b1;
                end
                ST_CHECK:
                begin
                    check_next = byte_in;
                end
                ST_TRAIL1:
                begin
                    terr_next = (byte_in != cfg.trailer_first);
                end
                default:
                begin
                    prev_next  = 8'd0;
                    idx_next   = '0;
                    len_next   = 8'd0;
                    crc_next   = 8'd0;
                    check_next = 8'd0;
                    terr_next  = 1'b0;
                end
            endcase
        end
    end

    // result
    always_comb
    begin
        res.valid  = byte_valid && (state_reg == ST_TRAIL2);
        res.word_a = {store_reg[3], store_reg[2], store_reg[1], store_reg[0]};
        res.word_b = {store_reg[7], store_reg[6], store_reg[5], store_reg[4]};
        res.word_c = {store_reg[11], store_reg[10], store_reg[9], store_reg[8]};
        res.word_d = {store_reg[15], store_reg[14], store_reg[13], store_reg[12]};
        if (len_bad)
        begin
            res.frame_status = STATUS_BAD_LENGTH;
        end
        else if (trailer_bad)
        begin
            res.frame_status = STATUS_TRAILER_ERR;
        end
        else if (crc8_update(crc_reg, 8'd0) != check_reg)
        begin
            res.frame_status = STATUS_CHECK_ERR;
        end
        else
        begin
            res.frame_status = STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HUNT;
            prev_reg  <= 8'd0;
            idx_reg   <= '0;
            len_reg   <= 8'd0;
            crc_reg   <= 8'd0;
            check_reg <= 8'd0;
            terr_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            prev_reg  <= prev_next;
            idx_reg   <= idx_next;
            len_reg   <= len_next;
            crc_reg   <= crc_next;
            check_reg <= check_next;
            terr_reg  <= terr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        store_reg <= store_next;
    end

`ifndef SYNTHESIS
    a_close_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |=> state_reg == ST_HUNT)
        else $error("frame close did not return to sync search");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PAYLOAD |-> idx_reg < IDX_W'(PAYLOAD_BYTES))
        else $error("payload index out of range");

    a_zero_len_skip: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LENGTH && byte_valid && byte_in == 8'd0) |=> state_reg == ST_CHECK)
        else $error("zero length did not skip payload");
`endif

endmodule
